/* design/gcim_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the grid cell index mapper.
// Has no dependencies; imported by grid_cell_index_mapper.
package gcim_pkg;

  localparam int CELLS_X = 16;
  localparam int CELLS_Y = 16;
  localparam int CELLS_Z = 16;

  localparam int CELLS [3] = '{CELLS_X, CELLS_Y, CELLS_Z};
  localparam int PLANE = CELLS_Y * CELLS_Z;
  localparam int TOTAL = CELLS_X * PLANE;

  localparam int CNT_MAX_XY = (CELLS_X > CELLS_Y) ? CELLS_X : CELLS_Y;
  localparam int CNT_MAX = (CNT_MAX_XY > CELLS_Z) ? CNT_MAX_XY : CELLS_Z;

  localparam int FIX_W   = 32;
  localparam int COORD_F = 4;
  localparam int INDEX_F = 12;
  localparam int WR_IDX_W = 3;
  localparam int CLOG_MAX = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;
  localparam int COORD_W = (CLOG_MAX > COORD_F) ? CLOG_MAX : COORD_F;

  typedef enum logic [1:0] {
    REQ_POINT = 2'd0,
    REQ_INDEX = 2'd1,
    REQ_BOX   = 2'd2,
    REQ_WIDE  = 2'd3
  } req_t;

  localparam logic [WR_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [WR_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [WR_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [WR_IDX_W-1:0] REG_SCALE_X  = 3'd3;
  localparam logic [WR_IDX_W-1:0] REG_SCALE_Y  = 3'd4;
  localparam logic [WR_IDX_W-1:0] REG_SCALE_Z  = 3'd5;

  localparam logic [FIX_W-1:0] SCALE_RESET = 32'h0001_0000;

endpackage

/* design/grid_cell_index_mapper.sv */
`timescale 1ns / 1ps
// Top level of the grid cell index mapper: configuration registers and a
// five-stage pipeline. Depends on gcim_pkg.

// The block accepts one request per cycle and answers each with one result,
// marked by done for a single cycle. The result passes through the pipeline
// stages in order: point ordering, origin subtraction, the 32 by 32 bit scale
// multipliers, clamping and widening, and the linear index. The receiver
// cannot stall, so busy stays low and results are never held back.
module grid_cell_index_mapper (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    req_type,
  input  logic signed [31:0]            pa_x,
  input  logic signed [31:0]            pa_y,
  input  logic signed [31:0]            pa_z,
  input  logic signed [31:0]            pb_x,
  input  logic signed [31:0]            pb_y,
  input  logic signed [31:0]            pb_z,
  input  logic [11:0]                   query_index,
  input  logic                          wr_en,
  input  logic [gcim_pkg::WR_IDX_W-1:0] wr_index,
  input  logic [31:0]                   wr_data,
  output logic                          done,
  output logic [11:0]                   cell_index,
  output logic [3:0]                    lo_x,
  output logic [3:0]                    lo_y,
  output logic [3:0]                    lo_z,
  output logic [3:0]                    hi_x,
  output logic [3:0]                    hi_y,
  output logic [3:0]                    hi_z,
  output logic                          in_range
);
  import gcim_pkg::*;

  logic signed [FIX_W-1:0] origin [3];
  logic [FIX_W-1:0]        scale [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        origin[i] <= '0;
        scale[i]  <= SCALE_RESET;
      end
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ORIGIN_X: origin[0] <= wr_data;
        REG_ORIGIN_Y: origin[1] <= wr_data;
        REG_ORIGIN_Z: origin[2] <= wr_data;
        REG_SCALE_X:  scale[0]  <= wr_data;
        REG_SCALE_Y:  scale[1]  <= wr_data;
        REG_SCALE_Z:  scale[2]  <= wr_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic v1, v2, v3, v4, v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5} <= '0;
    end else begin
      v1 <= start & ~busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // Stage 1: order the two points per axis for box and wide requests; else point a is used for both.
  logic signed [FIX_W-1:0] pa [3];
  logic signed [FIX_W-1:0] pb [3];
  logic signed [FIX_W-1:0] mn1 [3];
  logic signed [FIX_W-1:0] mx1 [3];
  req_t                    req1;
  logic [INDEX_F-1:0]      q1;

  assign pa = '{pa_x, pa_y, pa_z};
  assign pb = '{pb_x, pb_y, pb_z};

  always_ff @(posedge clk) begin
    req1 <= req_t'(req_type);
    q1   <= query_index;
    for (int i = 0; i < 3; i++) begin
      if (req_type[1] && (pb[i] < pa[i])) begin
        mn1[i] <= pb[i];
        mx1[i] <= pa[i];
      end else if (req_type[1]) begin
        mn1[i] <= pa[i];
        mx1[i] <= pb[i];
      end else begin
        mn1[i] <= pa[i];
        mx1[i] <= pa[i];
      end
    end
  end

  // Stage 2: offsets from the origin; a negative offset maps to cell zero.
  logic [FIX_W:0]     dlo [3];
  logic [FIX_W:0]     dhi [3];
  logic               neg_lo2 [3];
  logic               neg_hi2 [3];
  logic [FIX_W-1:0]   off_lo2 [3];
  logic [FIX_W-1:0]   off_hi2 [3];
  req_t               req2;
  logic [INDEX_F-1:0] q2;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dlo[i] = {mn1[i][FIX_W-1], mn1[i]} - {origin[i][FIX_W-1], origin[i]};
      dhi[i] = {mx1[i][FIX_W-1], mx1[i]} - {origin[i][FIX_W-1], origin[i]};
    end
  end

  always_ff @(posedge clk) begin
    req2 <= req1;
    q2   <= q1;
    for (int i = 0; i < 3; i++) begin
      neg_lo2[i] <= dlo[i][FIX_W];
      neg_hi2[i] <= dhi[i][FIX_W];
      off_lo2[i] <= dlo[i][FIX_W-1:0];
      off_hi2[i] <= dhi[i][FIX_W-1:0];
    end
  end

  // Stage 3: scale to whole cells.
  logic [2*FIX_W-1:0] plo [3];
  logic [2*FIX_W-1:0] phi [3];
  logic [FIX_W-1:0]   raw_lo3 [3];
  logic [FIX_W-1:0]   raw_hi3 [3];
  req_t               req3;
  logic [INDEX_F-1:0] q3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      plo[i] = {{FIX_W{1'b0}}, off_lo2[i]} * {{FIX_W{1'b0}}, scale[i]};
      phi[i] = {{FIX_W{1'b0}}, off_hi2[i]} * {{FIX_W{1'b0}}, scale[i]};
    end
  end

  always_ff @(posedge clk) begin
    req3 <= req2;
    q3   <= q2;
    for (int i = 0; i < 3; i++) begin
      raw_lo3[i] <= neg_lo2[i] ? '0 : plo[i][2*FIX_W-1:FIX_W];
      raw_hi3[i] <= neg_hi2[i] ? '0 : phi[i][2*FIX_W-1:FIX_W];
    end
  end

  // Stage 4: clamp to the grid, widen, or split a linear index.
  logic [COORD_W-1:0] cl_lo [3];
  logic [COORD_W-1:0] cl_hi [3];
  logic [COORD_W-1:0] top [3];
  logic [FIX_W-1:0]   qw;
  logic [FIX_W-1:0]   qrem;
  logic [COORD_W-1:0] lo4 [3];
  logic [COORD_W-1:0] hi4 [3];
  logic               ok4;
  req_t               req4;
  logic [INDEX_F-1:0] q4;

  always_comb begin
    qw   = FIX_W'(q3);
    qrem = qw % FIX_W'(PLANE);
    for (int i = 0; i < 3; i++) begin
      top[i]   = COORD_W'(CELLS[i] - 1);
      cl_lo[i] = (raw_lo3[i] > FIX_W'(CELLS[i] - 1)) ? top[i] : raw_lo3[i][COORD_W-1:0];
      cl_hi[i] = (raw_hi3[i] > FIX_W'(CELLS[i] - 1)) ? top[i] : raw_hi3[i][COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    req4 <= req3;
    q4   <= q3;
    ok4  <= !((req3 == REQ_INDEX) && (qw >= FIX_W'(TOTAL)));
    unique case (req3)
      REQ_INDEX: begin
        if (qw >= FIX_W'(TOTAL)) begin
          for (int i = 0; i < 3; i++) begin
            lo4[i] <= '0;
            hi4[i] <= '0;
          end
        end else begin
          lo4[0] <= COORD_W'(qw / FIX_W'(PLANE));
          hi4[0] <= COORD_W'(qw / FIX_W'(PLANE));
          lo4[1] <= COORD_W'(qrem / FIX_W'(CELLS_Z));
          hi4[1] <= COORD_W'(qrem / FIX_W'(CELLS_Z));
          lo4[2] <= COORD_W'(qrem % FIX_W'(CELLS_Z));
          hi4[2] <= COORD_W'(qrem % FIX_W'(CELLS_Z));
        end
      end
      REQ_WIDE: begin
        for (int i = 0; i < 3; i++) begin
          lo4[i] <= (cl_lo[i] != '0) ? cl_lo[i] - COORD_W'(1) : cl_lo[i];
          hi4[i] <= (cl_hi[i] < top[i]) ? cl_hi[i] + COORD_W'(1) : cl_hi[i];
        end
      end
      default: begin
        for (int i = 0; i < 3; i++) begin
          lo4[i] <= cl_lo[i];
          hi4[i] <= cl_hi[i];
        end
      end
    endcase
  end

  // Stage 5: linear index of the low corner and the result registers.
  logic [FIX_W-1:0] lin;

  assign lin = FIX_W'(lo4[0]) * FIX_W'(PLANE) + FIX_W'(lo4[1]) * FIX_W'(CELLS_Z)
             + FIX_W'(lo4[2]);

  always_ff @(posedge clk) begin
    cell_index <= (req4 == REQ_INDEX) ? q4 : lin[INDEX_F-1:0];
    lo_x       <= lo4[0][COORD_F-1:0];
    lo_y       <= lo4[1][COORD_F-1:0];
    lo_z       <= lo4[2][COORD_F-1:0];
    hi_x       <= hi4[0][COORD_F-1:0];
    hi_y       <= hi4[1][COORD_F-1:0];
    hi_z       <= hi4[2][COORD_F-1:0];
    in_range   <= ok4;
  end

  assign done = v5;

endmodule
